@@ rtl/etws_pkg.sv @@
// Shared types and constants for the elapsed time window statistics block.
package etws_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned CFG_W  = 32;
    localparam int unsigned RATE_W = 32;

    // Rate reported for an empty ring or a zero mean.
    localparam logic [RATE_W-1:0] EMPTY_RATE = 32'd1000;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_RECORD = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;

    localparam logic REG_TICKS_PER_MS     = 1'b0;
    localparam logic REG_TICKS_PER_SECOND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MEAN,
        ST_LO,
        ST_HI,
        ST_AVG,
        ST_RATE
    } state_t;

    typedef struct packed {
        logic              go;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/etws_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module etws_div (
    input  logic              clk,
    input  logic              rst_n,
    input  etws_pkg::div_req_t req,
    output etws_pkg::div_rsp_t rsp
);

    localparam int unsigned W     = etws_pkg::DATA_W;
    localparam int unsigned CNT_W = $clog2(W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [W:0]       trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[W-1]};
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[W-1:0];
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ rtl/elapsed_time_window_stats.sv @@
// Top level: windowed min, max and mean of elapsed-time samples held in a ring memory.
//
//   channel   handshake            payload
//   --------  -------------------  ----------------------------------------------
//   command   start, busy          action, now
//   result    done (one cycle)     elapsed, lowest_ms, highest_ms, average_ms, rate
//   config    cfg_write            cfg_index, cfg_data
//
// Start, record and unused actions and a report of an empty ring never raise busy.
// Any other report scans the sample memory, then runs five divisions on the shared divider
// (mean, lowest, highest, average, rate); the rate division is skipped when the mean is zero.
// Every result shows in the cycle after the item ends. Reset clears the counters and start
// time; the sample memory is not cleared. The receiver cannot stall: done is one cycle.
module elapsed_time_window_stats #(
    parameter int unsigned WINDOW = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] now,
    output logic        done,
    output logic [63:0] elapsed,
    output logic [63:0] lowest_ms,
    output logic [63:0] highest_ms,
    output logic [63:0] average_ms,
    output logic [31:0] rate,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int unsigned W     = etws_pkg::DATA_W;
    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);

    etws_pkg::state_t   state_reg, state_next;
    etws_pkg::div_req_t div_req;
    etws_pkg::div_rsp_t div_rsp;

    logic [etws_pkg::CFG_W-1:0] tpm_reg, tps_reg;
    logic [W-1:0]     tpm_eff;
    logic [W-1:0]     start_time_reg, start_time_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic [CNT_W-1:0] rcv_reg, rcv_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             launch_reg, launch_next;
    logic [W-1:0]     sum_reg, sum_next;
    logic [W-1:0]     mn_reg, mn_next;
    logic [W-1:0]     mx_reg, mx_next;
    logic [W-1:0]     mean_reg, mean_next;
    logic [W-1:0]     lo_reg, lo_next;
    logic [W-1:0]     hi_reg, hi_next;
    logic [W-1:0]     avg_reg, avg_next;

    logic             done_reg, done_next;
    logic [W-1:0]     elapsed_reg, elapsed_next;
    logic [W-1:0]     lowest_reg, lowest_next;
    logic [W-1:0]     highest_reg, highest_next;
    logic [W-1:0]     average_reg, average_next;
    logic [etws_pkg::RATE_W-1:0] rate_reg, rate_next;

    logic [W-1:0]     sample_mem [0:WINDOW-1];
    logic [W-1:0]     mem_q_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    logic [W-1:0]     mem_wdata;

    // A zero divisor register is out of range and behaves as one.
    assign tpm_eff = (tpm_reg == '0) ? W'(1) : W'(tpm_reg);

    etws_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sample_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= sample_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpm_reg <= 32'd1000;
            tps_reg <= 32'd1000000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                etws_pkg::REG_TICKS_PER_MS:     tpm_reg <= cfg_data;
                etws_pkg::REG_TICKS_PER_SECOND: tps_reg <= cfg_data;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        start_time_next = start_time_reg;
        wr_idx_next     = wr_idx_reg;
        count_next      = count_reg;
        iss_next        = iss_reg;
        rcv_next        = rcv_reg;
        rd_vld_next     = 1'b0;
        launch_next     = 1'b0;
        sum_next        = sum_reg;
        mn_next         = mn_reg;
        mx_next         = mx_reg;
        mean_next       = mean_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        avg_next        = avg_reg;
        done_next       = 1'b0;
        elapsed_next    = elapsed_reg;
        lowest_next     = lowest_reg;
        highest_next    = highest_reg;
        average_next    = average_reg;
        rate_next       = rate_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_idx_reg;
        mem_wdata       = now - start_time_reg;
        mem_raddr       = iss_reg[IDX_W-1:0];
        div_req.go      = 1'b0;
        div_req.dividend = sum_reg;
        div_req.divisor  = W'(count_reg);

        unique case (state_reg)
            etws_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    done_next    = 1'b1;
                    elapsed_next = '0;
                    lowest_next  = '0;
                    highest_next = '0;
                    average_next = '0;
                    rate_next    = '0;
                    unique case (action)
                        etws_pkg::ACT_START:
                        begin
                            start_time_next = now;
                        end
                        etws_pkg::ACT_RECORD:
                        begin
                            mem_we       = 1'b1;
                            elapsed_next = mem_wdata;
                            wr_idx_next  = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + 1'b1;
                            if (count_reg != FULL_CNT)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        etws_pkg::ACT_REPORT:
                        begin
                            if (count_reg == '0)
                            begin
                                rate_next = etws_pkg::EMPTY_RATE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = etws_pkg::ST_SCAN;
                                iss_next   = '0;
                                rcv_next   = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            etws_pkg::ST_SCAN:
            begin
                // Reads are issued one per cycle; the read data is registered and returns in the next cycle.
                if (iss_reg != count_reg)
                begin
                    iss_next    = iss_reg + 1'b1;
                    rd_vld_next = 1'b1;
                end
                if (rd_vld_reg)
                begin
                    if (rcv_reg == '0)
                    begin
                        sum_next = mem_q_reg;
                        mn_next  = mem_q_reg;
                        mx_next  = mem_q_reg;
                    end
                    else
                    begin
                        sum_next = sum_reg + mem_q_reg;
                        if (mem_q_reg < mn_reg)
                        begin
                            mn_next = mem_q_reg;
                        end
                        if (mem_q_reg > mx_reg)
                        begin
                            mx_next = mem_q_reg;
                        end
                    end
                    rcv_next = rcv_reg + 1'b1;
                    if (rcv_reg + 1'b1 == count_reg)
                    begin
                        state_next  = etws_pkg::ST_MEAN;
                        launch_next = 1'b1;
                    end
                end
            end

            etws_pkg::ST_MEAN:
            begin
                div_req.go = launch_reg;
                if (div_rsp.done)
                begin
                    mean_next   = div_rsp.quotient;
                    state_next  = etws_pkg::ST_LO;
                    launch_next = 1'b1;
                end
            end

            etws_pkg::ST_LO:
            begin
                div_req.go       = launch_reg;
                div_req.dividend = mn_reg;
                div_req.divisor  = tpm_eff;
                if (div_rsp.done)
                begin
                    lo_next     = div_rsp.quotient;
                    state_next  = etws_pkg::ST_HI;
                    launch_next = 1'b1;
                end
            end

            etws_pkg::ST_HI:
            begin
                div_req.go       = launch_reg;
                div_req.dividend = mx_reg;
                div_req.divisor  = tpm_eff;
                if (div_rsp.done)
                begin
                    hi_next     = div_rsp.quotient;
                    state_next  = etws_pkg::ST_AVG;
                    launch_next = 1'b1;
                end
            end

            etws_pkg::ST_AVG:
            begin
                div_req.go       = launch_reg;
                div_req.dividend = mean_reg;
                div_req.divisor  = tpm_eff;
                if (div_rsp.done)
                begin
                    avg_next    = div_rsp.quotient;
                    state_next  = etws_pkg::ST_RATE;
                    launch_next = 1'b1;
                end
            end

            etws_pkg::ST_RATE:
            begin
                div_req.go       = launch_reg && (mean_reg != '0);
                div_req.dividend = W'(tps_reg);
                div_req.divisor  = mean_reg;
                if ((launch_reg && mean_reg == '0) || div_rsp.done)
                begin
                    done_next    = 1'b1;
                    elapsed_next = '0;
                    lowest_next  = lo_reg;
                    highest_next = hi_reg;
                    average_next = avg_reg;
                    // The quotient cannot exceed the 32-bit numerator.
                    rate_next    = (mean_reg == '0) ? etws_pkg::EMPTY_RATE
                                                    : div_rsp.quotient[etws_pkg::RATE_W-1:0];
                    state_next   = etws_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = etws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= etws_pkg::ST_IDLE;
            start_time_reg <= '0;
            wr_idx_reg     <= '0;
            count_reg      <= '0;
            iss_reg        <= '0;
            rcv_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            launch_reg     <= 1'b0;
            sum_reg        <= '0;
            mn_reg         <= '0;
            mx_reg         <= '0;
            mean_reg       <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            avg_reg        <= '0;
            done_reg       <= 1'b0;
            elapsed_reg    <= '0;
            lowest_reg     <= '0;
            highest_reg    <= '0;
            average_reg    <= '0;
            rate_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            start_time_reg <= start_time_next;
            wr_idx_reg     <= wr_idx_next;
            count_reg      <= count_next;
            iss_reg        <= iss_next;
            rcv_reg        <= rcv_next;
            rd_vld_reg     <= rd_vld_next;
            launch_reg     <= launch_next;
            sum_reg        <= sum_next;
            mn_reg         <= mn_next;
            mx_reg         <= mx_next;
            mean_reg       <= mean_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            avg_reg        <= avg_next;
            done_reg       <= done_next;
            elapsed_reg    <= elapsed_next;
            lowest_reg     <= lowest_next;
            highest_reg    <= highest_next;
            average_reg    <= average_next;
            rate_reg       <= rate_next;
        end
    end

    assign busy       = (state_reg != etws_pkg::ST_IDLE);
    assign done       = done_reg;
    assign elapsed    = elapsed_reg;
    assign lowest_ms  = lowest_reg;
    assign highest_ms = highest_reg;
    assign average_ms = average_reg;
    assign rate       = rate_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("sample count exceeds the window");

    a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == etws_pkg::ST_SCAN) |-> (iss_reg <= count_reg && rcv_reg < count_reg))
        else $error("scan ran past the stored samples");

    a_div_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == etws_pkg::ST_MEAN || state_reg == etws_pkg::ST_LO ||
                          state_reg == etws_pkg::ST_HI || state_reg == etws_pkg::ST_AVG ||
                          state_reg == etws_pkg::ST_RATE))
        else $error("divider finished outside a division step");

    a_report_ends_in_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == etws_pkg::ST_RATE && state_next == etws_pkg::ST_IDLE) |=> done)
        else $error("report finished without a result");

    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == etws_pkg::ST_IDLE && !rd_vld_reg))
        else $error("sample memory written during a report");

endmodule

@@ tb/etws_result_checker.sv @@
// Result checker for the elapsed time window statistics block: predicts every result and compares.
module etws_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  action,
    input  logic [63:0] now,
    input  logic        done,
    input  logic [63:0] elapsed,
    input  logic [63:0] lowest_ms,
    input  logic [63:0] highest_ms,
    input  logic [63:0] average_ms,
    input  logic [31:0] rate,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output int          pending,
    output int          failures
);

    localparam int RING_DEPTH = 64;

    typedef struct {
        logic [63:0] elapsed;
        logic [63:0] lowest_ms;
        logic [63:0] highest_ms;
        logic [63:0] average_ms;
        logic [31:0] rate;
    } timing_stats_t;

    timing_stats_t expected_stats[$];
    timing_stats_t want;

    logic [63:0] sample_ring [RING_DEPTH];
    logic [5:0]  next_slot;
    logic [6:0]  filled;
    logic [63:0] mark_time;
    logic [31:0] ms_divisor;
    logic [31:0] per_second;

    // Advances the window state by one item and returns the statistics it produces.
    function automatic timing_stats_t window_stats_outcome(input logic [1:0] act,
                                                           input logic [63:0] stamp);
        timing_stats_t r;
        logic [63:0]   total;
        logic [63:0]   least;
        logic [63:0]   most;
        logic [63:0]   mean;
        logic [63:0]   divisor;
        int            i;
        r = '{default: '0};
        case (act)
            etws_pkg::ACT_START:
            begin
                mark_time = stamp;
            end
            etws_pkg::ACT_RECORD:
            begin
                r.elapsed = stamp - mark_time;
                sample_ring[next_slot] = r.elapsed;
                next_slot = next_slot + 6'd1;
                if (filled < RING_DEPTH)
                begin
                    filled = filled + 7'd1;
                end
            end
            etws_pkg::ACT_REPORT:
            begin
                if (filled == 0)
                begin
                    r.rate = etws_pkg::EMPTY_RATE;
                end
                else
                begin
                    total = '0;
                    least = sample_ring[0];
                    most  = sample_ring[0];
                    for (i = 0; i < filled; i++)
                    begin
                        total = total + sample_ring[i];
                        if (sample_ring[i] < least)
                        begin
                            least = sample_ring[i];
                        end
                        if (sample_ring[i] > most)
                        begin
                            most = sample_ring[i];
                        end
                    end
                    mean = total / {57'd0, filled};
                    // A zero divisor is out of range and behaves as one tick per millisecond.
                    divisor = (ms_divisor == 0) ? 64'd1 : {32'd0, ms_divisor};
                    r.lowest_ms  = least / divisor;
                    r.highest_ms = most / divisor;
                    r.average_ms = mean / divisor;
                    if (mean == 0)
                    begin
                        r.rate = etws_pkg::EMPTY_RATE;
                    end
                    else
                    begin
                        r.rate = 32'({32'd0, per_second} / mean);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic check_field(input string label, input logic [63:0] exp_val,
                               input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, label, exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_stats.delete();
            next_slot  = '0;
            filled     = '0;
            mark_time  = '0;
            ms_divisor = 32'd1000;
            per_second = 32'd1000000;
            failures   = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_stats.size() == 0)
                begin
                    failures++;
                    $display("%0t: stray result, expected none, actual elapsed %0h rate %0h",
                             $time, elapsed, rate);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    check_field("elapsed", want.elapsed, elapsed);
                    check_field("lowest_ms", want.lowest_ms, lowest_ms);
                    check_field("highest_ms", want.highest_ms, highest_ms);
                    check_field("average_ms", want.average_ms, average_ms);
                    check_field("rate", {32'd0, want.rate}, {32'd0, rate});
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    etws_pkg::REG_TICKS_PER_MS:     ms_divisor = cfg_data;
                    etws_pkg::REG_TICKS_PER_SECOND: per_second = cfg_data;
                    default:                        ;
                endcase
            end
            if (start && !busy)
            begin
                expected_stats.push_back(window_stats_outcome(action, now));
            end
            pending = expected_stats.size();
        end
    end

endmodule

@@ tb/tb_elapsed_time_window_stats.sv @@
// Testbench top for the elapsed time window statistics block: clock, reset, stimulus, verdict.
module tb_elapsed_time_window_stats;

    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 2_000_000;
    localparam int         RANDOM_ITEMS = 650;
    localparam int         PHASE_ITEMS  = 130;
    localparam logic [63:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [63:0] now;
    logic        done;
    logic [63:0] elapsed;
    logic [63:0] lowest_ms;
    logic [63:0] highest_ms;
    logic [63:0] average_ms;
    logic [31:0] rate;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;

    int pending;
    int failures;
    int cycles;
    int items_sent;
    bit gaps_enabled;

    elapsed_time_window_stats DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .now        (now),
        .done       (done),
        .elapsed    (elapsed),
        .lowest_ms  (lowest_ms),
        .highest_ms (highest_ms),
        .average_ms (average_ms),
        .rate       (rate),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    etws_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .now        (now),
        .done       (done),
        .elapsed    (elapsed),
        .lowest_ms  (lowest_ms),
        .highest_ms (highest_ms),
        .average_ms (average_ms),
        .rate       (rate),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .failures   (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand_stamp();
        return {$urandom, $urandom};
    endfunction

    // Elapsed spans: mostly modest, with zero, huge, all-ones and backward steps mixed in.
    function automatic logic [63:0] rand_span();
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            6:       return {32'd0, $urandom};
            7:       return rand_stamp();
            8:       return 64'd0 - 64'($urandom_range(1, 1000));
            9:       return ALL_ONES;
            default: return 64'($urandom_range(0, 2_000_000));
        endcase
    endfunction

    function automatic logic [31:0] rand_setting();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'd1000;
            4:       return 32'd1000000;
            5:       return 32'($urandom_range(1, 100000));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [63:0] stamp);
        if (gaps_enabled && $urandom_range(0, 99) < 16)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
        end
        @(negedge clk);
        start  <= 1'b1;
        action <= act;
        now    <= stamp;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        items_sent++;
    endtask

    // Holds the command side off until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_rates(input logic [31:0] per_ms, input logic [31:0] per_sec);
        drain();
        write_reg(etws_pkg::REG_TICKS_PER_MS, per_ms);
        write_reg(etws_pkg::REG_TICKS_PER_SECOND, per_sec);
    endtask

    initial
    begin : stimulus
        logic [63:0] base;
        int          burst;
        int          k;
        int          random_sent;
        int          next_phase;

        rst_n        = 1'b0;
        start        = 1'b0;
        action       = etws_pkg::ACT_START;
        now          = '0;
        cfg_write    = 1'b0;
        cfg_index    = etws_pkg::REG_TICKS_PER_MS;
        cfg_data     = '0;
        items_sent   = 0;
        gaps_enabled = 1'b1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, starting from the reset settings.
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        send_item(ACT_UNUSED, ALL_ONES);
        send_item(etws_pkg::ACT_START, 64'd0);
        send_item(etws_pkg::ACT_RECORD, 64'd0);
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        send_item(etws_pkg::ACT_START, ALL_ONES);
        send_item(etws_pkg::ACT_RECORD, 64'd5);
        send_item(etws_pkg::ACT_RECORD, ALL_ONES);
        send_item(etws_pkg::ACT_START, 64'd100);
        send_item(etws_pkg::ACT_RECORD, 64'd50);
        send_item(etws_pkg::ACT_RECORD, 64'h8000_0000_0000_0000);
        send_item(etws_pkg::ACT_REPORT, ALL_ONES);
        send_item(ACT_UNUSED, 64'd0);
        set_rates(32'd0, 32'd0);
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        set_rates(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(etws_pkg::ACT_START, 64'd1000);
        send_item(etws_pkg::ACT_RECORD, 64'd1000 + 64'hFFFF_FFFF * 3);
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        set_rates(32'd1, 32'd1);
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        send_item(etws_pkg::ACT_START, 64'd12345);
        send_item(etws_pkg::ACT_RECORD, 64'd12352);
        send_item(etws_pkg::ACT_REPORT, 64'd0);
        set_rates(32'd1000, 32'd1000000);

        // Random part: start/record bursts with occasional reports, plus some noise.
        random_sent = 0;
        next_phase  = PHASE_ITEMS;
        while (random_sent < RANDOM_ITEMS)
        begin
            gaps_enabled = !(random_sent >= 250 && random_sent < 400);
            if (random_sent >= next_phase)
            begin
                set_rates(rand_setting(), rand_setting());
                next_phase += PHASE_ITEMS;
            end
            k = items_sent;
            if ($urandom_range(0, 99) < 8)
            begin
                send_item(2'($urandom_range(0, 3)), rand_stamp());
            end
            else
            begin
                base = ($urandom_range(0, 3) == 0) ? rand_stamp() : {32'd0, $urandom};
                send_item(etws_pkg::ACT_START, base);
                burst = $urandom_range(1, 6);
                repeat (burst) send_item(etws_pkg::ACT_RECORD, base + rand_span());
                if ($urandom_range(0, 99) < 40)
                begin
                    send_item(etws_pkg::ACT_REPORT, rand_stamp());
                end
            end
            if ($urandom_range(0, 99) < 5)
            begin
                drain();
            end
            random_sent += items_sent - k;
        end

        drain();
        repeat (20) @(posedge clk);
        if (failures == 0 && pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
